// ===== rtl/core/ddo_pkg.sv =====
// Shared constants, state type and arctangent table for the odometry block.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int COUNT_W   = 16;
    localparam int POS_W     = 32;
    localparam int ANG_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // The shared multiplier is 24 by 32 bits unsigned.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = 2 * MUL_A_W;
    localparam int SUM_W   = PROD_W + 1;

    // CORDIC datapath width, with headroom above the Q2.30 values.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [CFG_W-1:0] MPC_RESET  = 32'd113320;
    localparam logic [CFG_W-1:0] GAIN_RESET = 32'd2550626170;

    localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN     = 1'b1;

    localparam logic REQ_CLEAR = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_MUL,
        ST_DIF_MUL,
        ST_HEAD_LO,
        ST_HEAD_HI,
        ST_HEAD_SUM,
        ST_ROT_INIT,
        ST_ROT,
        ST_QUAD,
        ST_ADV_LO,
        ST_ADV_HI,
        ST_ADV_SUM,
        ST_DONE
    } ddo_state_t;

    // Arctangent of 2^-idx in binary angle units (2^32 per turn).
    function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/differential_drive_odometry.sv =====
// Differential drive odometry: pose tracker with a shared multiplier and serial CORDIC.
`timescale 1ns / 1ps
`default_nettype none

// This block tracks the pose of a two-wheel robot by dead reckoning. An item with
// req_type 0 clears x, y and heading to zero; an item with req_type 1 brings the
// signed left and right encoder counts of one interval. Travel is counts times
// metres_per_count (Q0.32); the heading changes by the left minus right travel
// times heading_gain, and the position advances by the mean travel along the
// heading at the middle of the interval. Positions are signed Q16.16 (FRAC_BITS
// fraction bits) and saturate; heading is a 32-bit binary angle that wraps.
// Every item returns one pose. A travel item runs the CORDIC rotation, one
// micro-rotation per cycle through one shift-and-add unit, and eight passes
// through the single 24x32 multiplier before the next item can be accepted; a
// clear item goes straight to the output step. The finished pose sits in an
// output register, so the next item can be accepted while it waits to be taken;
// a later pose that finishes while that register is still full holds the block
// until the waiting pose is taken.
// Configuration writes are always accepted and must only be issued while idle.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,

    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [ddo_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire  [ddo_pkg::CFG_W-1:0]              cfg_data,

    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire                                    s_req_type,
    input  wire  signed [ddo_pkg::COUNT_W-1:0]     s_left_count,
    input  wire  signed [ddo_pkg::COUNT_W-1:0]     s_right_count,

    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [ddo_pkg::POS_W-1:0]       m_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]       m_pos_y,
    output logic        [ddo_pkg::ANG_W-1:0]       m_heading
);

    import ddo_pkg::*;

    // Step counter wide enough for every micro-rotation index.
    localparam int IW = $clog2(CORDIC_STEPS);
    // The scaled step is the combined product shifted down by 63 - FRAC_BITS;
    // the low 24 bits were already dropped when the partial products were summed.
    localparam int ADV_SHIFT = 63 - FRAC_BITS - MUL_A_W;
    localparam int EXT_W = SUM_W + 1;

    // Sequencer state.
    ddo_state_t state_reg, state_next;

    // Configuration registers.
    logic [CFG_W-1:0] mpc_reg, mpc_next;
    logic [CFG_W-1:0] gain_reg, gain_next;

    // Pose.
    logic [POS_W-1:0] x_reg, x_next;
    logic [POS_W-1:0] y_reg, y_next;
    logic [ANG_W-1:0] head_reg, head_next;

    // Item operands and intermediate results.
    logic signed [COUNT_W-1:0] left_reg, left_next;
    logic signed [COUNT_W-1:0] right_reg, right_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [MUL_B_W-1:0]        acc_reg, acc_next;
    logic [MAG_W-1:0]          s_mag_reg, s_mag_next;
    logic [MAG_W-1:0]          t_mag_reg, t_mag_next;
    logic                      s_neg_reg, s_neg_next;
    logic                      t_neg_reg, t_neg_next;
    logic [ANG_W-1:0]          mid_reg, mid_next;
    logic [1:0]                quad_reg, quad_next;
    logic                      sel_y_reg, sel_y_next;

    // CORDIC registers.
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [CW-1:0] cz_reg, cz_next;
    logic [IW-1:0]        step_reg, step_next;
    logic signed [CW-1:0] cos_reg, cos_next;
    logic signed [CW-1:0] sin_reg, sin_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_x_reg, out_x_next;
    logic [POS_W-1:0] out_y_reg, out_y_next;
    logic [ANG_W-1:0] out_h_reg, out_h_next;

    // Combinational datapath.
    logic                      in_fire;
    logic                      out_free;
    logic signed [COUNT_W:0]   wsum;
    logic signed [COUNT_W:0]   wdif;
    logic [COUNT_W:0]          wsum_mag;
    logic [COUNT_W:0]          wdif_mag;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [SUM_W-1:0]          psum;
    logic [ANG_W-1:0]          full_raw;
    logic [ANG_W-1:0]          half_raw;
    logic [ANG_W-1:0]          full_turn;
    logic [ANG_W-1:0]          half_turn;
    logic [ANG_W-1:0]          quad_add;
    logic [1:0]                quad_new;
    logic [ANG_W-1:0]          rest;
    logic signed [CW-1:0]      xs;
    logic signed [CW-1:0]      ys;
    logic signed [CW-1:0]      atan_val;
    logic signed [CW-1:0]      trig;
    logic                      trig_neg;
    logic [CW-1:0]             trig_abs;
    logic [SUM_W-1:0]          dstep;
    logic signed [EXT_W-1:0]   dsigned;
    logic signed [EXT_W-1:0]   pose_ext;
    logic signed [EXT_W-1:0]   pose_sum;
    logic [POS_W-1:0]          pose_sat;
    logic [POS_W-1:0]          pose_old;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_pos_x   = out_x_reg;
    assign m_pos_y   = out_y_reg;
    assign m_heading = out_h_reg;

    // Wheel sum and difference, and their magnitudes.
    assign wsum     = {left_reg[COUNT_W-1], left_reg} + {right_reg[COUNT_W-1], right_reg};
    assign wdif     = {left_reg[COUNT_W-1], left_reg} - {right_reg[COUNT_W-1], right_reg};
    assign wsum_mag = wsum[COUNT_W] ? (COUNT_W+1)'(-wsum) : wsum;
    assign wdif_mag = wdif[COUNT_W] ? (COUNT_W+1)'(-wdif) : wdif;

    // Sum of the high partial product and the carried-down low partial product.
    assign psum = {1'b0, prod_reg} + SUM_W'(acc_reg);

    // Heading change and half change, both modulo a full turn.
    assign full_raw  = psum[ANG_W+7:8];
    assign half_raw  = psum[ANG_W+8:9];
    assign full_turn = t_neg_reg ? (ANG_W)'(-full_raw) : full_raw;
    assign half_turn = t_neg_reg ? (ANG_W)'(-half_raw) : half_raw;

    // Nearest quarter turn and the rest within an eighth turn.
    assign quad_add = mid_reg + 32'h2000_0000;
    assign quad_new = quad_add[ANG_W-1:ANG_W-2];
    assign rest     = mid_reg - {quad_new, {(ANG_W-2){1'b0}}};

    // One micro-rotation: arithmetic shifts round toward minus infinity.
    assign xs       = cx_reg >>> step_reg;
    assign ys       = cy_reg >>> step_reg;
    assign atan_val = CW'(atan_lut(5'(step_reg)));

    // Cosine or sine for the axis being advanced.
    assign trig     = sel_y_reg ? sin_reg : cos_reg;
    assign trig_neg = trig[CW-1];
    assign trig_abs = trig_neg ? CW'(-trig) : trig;

    // Position step, signed, then added with saturation to the signed range.
    assign dstep    = psum >> ADV_SHIFT;
    assign dsigned  = (s_neg_reg ^ trig_neg) ? -$signed({1'b0, dstep})
                                             :  $signed({1'b0, dstep});
    assign pose_old = sel_y_reg ? y_reg : x_reg;
    assign pose_ext = EXT_W'($signed(pose_old));
    assign pose_sum = pose_ext + dsigned;

    always_comb begin
        if (!pose_sum[EXT_W-1] && (pose_sum[EXT_W-2:POS_W-1] != '0)) begin
            pose_sat = {1'b0, {(POS_W-1){1'b1}}};
        end else if (pose_sum[EXT_W-1] && (pose_sum[EXT_W-2:POS_W-1] != '1)) begin
            pose_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pose_sat = pose_sum[POS_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_req_type == REQ_CLEAR) ? ST_DONE : ST_SUM_MUL;
                end
            end
            ST_SUM_MUL:  state_next = ST_DIF_MUL;
            ST_DIF_MUL:  state_next = ST_HEAD_LO;
            ST_HEAD_LO:  state_next = ST_HEAD_HI;
            ST_HEAD_HI:  state_next = ST_HEAD_SUM;
            ST_HEAD_SUM: state_next = ST_ROT_INIT;
            ST_ROT_INIT: state_next = ST_ROT;
            ST_ROT: begin
                if (step_reg == IW'(CORDIC_STEPS - 1)) begin
                    state_next = ST_QUAD;
                end
            end
            ST_QUAD:     state_next = ST_ADV_LO;
            ST_ADV_LO:   state_next = ST_ADV_HI;
            ST_ADV_HI:   state_next = ST_ADV_SUM;
            ST_ADV_SUM:  state_next = sel_y_reg ? ST_DONE : ST_ADV_LO;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        mul_a          = '0;
        mul_b          = '0;

        mpc_next       = mpc_reg;
        gain_next      = gain_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        head_next      = head_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        acc_next       = acc_reg;
        s_mag_next     = s_mag_reg;
        t_mag_next     = t_mag_reg;
        s_neg_next     = s_neg_reg;
        t_neg_next     = t_neg_reg;
        mid_next       = mid_reg;
        quad_next      = quad_reg;
        sel_y_next     = sel_y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        step_next      = step_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_h_next     = out_h_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_METRES_PER_COUNT: mpc_next  = cfg_data;
                REG_HEADING_GAIN:     gain_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    left_next  = s_left_count;
                    right_next = s_right_count;
                    if (s_req_type == REQ_CLEAR) begin
                        x_next    = '0;
                        y_next    = '0;
                        head_next = '0;
                    end
                end
            end
            ST_SUM_MUL: begin
                mul_a      = MUL_A_W'(wsum_mag);
                mul_b      = mpc_reg;
                s_neg_next = wsum[COUNT_W];
                t_neg_next = wdif[COUNT_W];
            end
            ST_DIF_MUL: begin
                mul_a      = MUL_A_W'(wdif_mag);
                mul_b      = mpc_reg;
                s_mag_next = prod_reg[MAG_W-1:0];
            end
            ST_HEAD_LO: begin
                mul_a      = prod_reg[MUL_A_W-1:0];
                mul_b      = gain_reg;
                t_mag_next = prod_reg[MAG_W-1:0];
            end
            ST_HEAD_HI: begin
                mul_a    = t_mag_reg[MAG_W-1:MUL_A_W];
                mul_b    = gain_reg;
                acc_next = prod_reg[PROD_W-1:MUL_A_W];
            end
            ST_HEAD_SUM: begin
                // The midpoint uses the heading before this interval's change.
                mid_next  = head_reg + half_turn;
                head_next = head_reg + full_turn;
            end
            ST_ROT_INIT: begin
                quad_next = quad_new;
                cx_next   = CORDIC_X0;
                cy_next   = '0;
                cz_next   = CW'($signed(rest));
                step_next = '0;
            end
            ST_ROT: begin
                if (!cz_reg[CW-1]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_val;
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_val;
                end
                step_next = step_reg + 1'b1;
            end
            ST_QUAD: begin
                case (quad_reg)
                    2'd0: begin
                        cos_next = cx_reg;
                        sin_next = cy_reg;
                    end
                    2'd1: begin
                        cos_next = -cy_reg;
                        sin_next = cx_reg;
                    end
                    2'd2: begin
                        cos_next = -cx_reg;
                        sin_next = -cy_reg;
                    end
                    default: begin
                        cos_next = cy_reg;
                        sin_next = -cx_reg;
                    end
                endcase
                sel_y_next = 1'b0;
            end
            ST_ADV_LO: begin
                mul_a = s_mag_reg[MUL_A_W-1:0];
                mul_b = trig_abs[MUL_B_W-1:0];
            end
            ST_ADV_HI: begin
                mul_a    = s_mag_reg[MAG_W-1:MUL_A_W];
                mul_b    = trig_abs[MUL_B_W-1:0];
                acc_next = prod_reg[PROD_W-1:MUL_A_W];
            end
            ST_ADV_SUM: begin
                if (sel_y_reg) begin
                    y_next = pose_sat;
                end else begin
                    x_next = pose_sat;
                end
                sel_y_next = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_h_next     = head_reg;
                end
            end
            default: ;
        endcase

        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mpc_reg       <= MPC_RESET;
            gain_reg      <= GAIN_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mpc_reg       <= mpc_next;
            gain_reg      <= gain_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        s_mag_reg <= s_mag_next;
        t_mag_reg <= t_mag_next;
        s_neg_reg <= s_neg_next;
        t_neg_reg <= t_neg_next;
        mid_reg   <= mid_next;
        quad_reg  <= quad_next;
        sel_y_reg <= sel_y_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        step_reg  <= step_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 1ps

module testbench;

    import ddo_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;

    // Arctangent of 2^-i in binary angle units, entry i at bits [32*i +: 32].
    localparam logic [32*32-1:0] ATAN_UNITS = {
        32'd0, 32'd1, 32'd1, 32'd3, 32'd5, 32'd10, 32'd20, 32'd41,
        32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608, 32'd5215, 32'd10430,
        32'd20861, 32'd41722, 32'd83443, 32'd166886, 32'd333772, 32'd667544,
        32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838, 32'd21354465,
        32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
    };

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                      req_type;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
    } wheel_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [ANG_W-1:0] heading;
    } pose_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_METRES_PER_COUNT;
    logic [CFG_W-1:0]          cfg_data  = '0;

    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_req_type    = REQ_CLEAR;
    logic signed [COUNT_W-1:0] s_left_count  = '0;
    logic signed [COUNT_W-1:0] s_right_count = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [POS_W-1:0]   m_pos_x;
    logic signed [POS_W-1:0]   m_pos_y;
    logic [ANG_W-1:0]          m_heading;

    differential_drive_odometry dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_heading     (m_heading)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the pose and of the two registers.
    logic [CFG_W-1:0] shadow_mpc  = MPC_RESET;
    logic [CFG_W-1:0] shadow_gain = GAIN_RESET;
    logic [POS_W-1:0] track_x     = '0;
    logic [POS_W-1:0] track_y     = '0;
    logic [ANG_W-1:0] track_head  = '0;

    wheel_item_t pending_items[$];
    pose_t       expected_poses[$];
    wheel_item_t next_item;
    pose_t       oldest_pose;
    int          items_taken = 0;
    int          errors      = 0;
    logic        item_taken  = 1'b0;
    logic        steady;

    // A window of items during which neither side idles.
    assign steady = (items_taken >= 600) && (items_taken < 800);

    // trunc(mag * b / 2^k), split into a 24-bit high and low half of mag.
    function automatic logic [63:0] mul_shift(logic [63:0] mag, logic [31:0] b, int k);
        logic [63:0] hi, lo, a, c;
        hi = (mag >> 24) & 64'hFFFFFF;
        lo = mag & 64'hFFFFFF;
        a  = hi * {32'd0, b};
        c  = lo * {32'd0, b};
        return (a + (c >> 24)) >> (k - 24);
    endfunction

    // Moves one coordinate by sign * trunc(|s| * |t| / 2^(63 - FRAC)), saturating at 32 bits.
    function automatic logic [POS_W-1:0] advance_axis(logic [POS_W-1:0] acc, longint s,
                                                      longint t);
        logic        neg;
        logic [63:0] ms, mt;
        longint      d, v;
        neg = (s < 0) != (t < 0);
        ms  = (s < 0) ? -s : s;
        mt  = (t < 0) ? -t : t;
        d   = mul_shift(ms, mt[31:0], 63 - FRAC);
        v   = {{32{acc[POS_W-1]}}, acc};
        v   = v + (neg ? -d : d);
        if (v > POS_MAX) v = POS_MAX;
        if (v < POS_MIN) v = POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // Updates the shadow pose with one item and returns the pose it must report.
    function automatic pose_t predict_pose(wheel_item_t it);
        longint      l, r, mpc, s, t, x, y, z, xs, ys, at, co, si;
        logic [63:0] mt, full, half;
        logic [31:0] mid, turned, zr;
        logic [1:0]  q;
        int          i;
        if (it.req_type == REQ_CLEAR) begin
            track_x    = '0;
            track_y    = '0;
            track_head = '0;
        end else begin
            l    = {{48{it.left_count[COUNT_W-1]}}, it.left_count};
            r    = {{48{it.right_count[COUNT_W-1]}}, it.right_count};
            mpc  = {32'd0, shadow_mpc};
            s    = (l + r) * mpc;
            t    = (l - r) * mpc;
            mt   = (t < 0) ? -t : t;
            full = mul_shift(mt, shadow_gain, 32);
            half = mul_shift(mt, shadow_gain, 33);
            if (t < 0) begin
                full = -full;
                half = -half;
            end
            mid = track_head + half[31:0];

            // Fold the angle to the nearest quarter turn, rotate the rest.
            turned = mid + 32'h20000000;
            q      = turned[31:30];
            zr     = mid - {q, 30'd0};
            z      = {{32{zr[31]}}, zr};
            x      = CORDIC_X0;
            y      = 0;
            for (i = 0; i < STEPS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                at = {32'd0, ATAN_UNITS[i*32 +: 32]};
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - at;
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + at;
                end
            end
            case (q)
                2'd0: begin co = x;  si = y;  end
                2'd1: begin co = -y; si = x;  end
                2'd2: begin co = -x; si = -y; end
                default: begin co = y; si = -x; end
            endcase

            track_x    = advance_axis(track_x, s, co);
            track_y    = advance_axis(track_y, s, si);
            track_head = track_head + full[31:0];
        end
        return '{pos_x: track_x, pos_y: track_y, heading: track_head};
    endfunction

    // Driver: inputs change on the falling edge only.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 26);
        if (aresetn && (!s_valid || item_taken)) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
                next_item = pending_items.pop_front();
                s_valid       <= 1'b1;
                s_req_type    <= next_item.req_type;
                s_left_count  <= next_item.left_count;
                s_right_count <= next_item.right_count;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: handshakes are seen on the rising edge, with pre-edge values.
    always @(posedge aclk) begin
        item_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_METRES_PER_COUNT: shadow_mpc  = cfg_data;
                    REG_HEADING_GAIN:     shadow_gain = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_poses.push_back(predict_pose('{req_type: s_req_type,
                    left_count: s_left_count, right_count: s_right_count}));
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pose x=%h y=%h heading=%h",
                                 m_pos_x, m_pos_y, m_heading);
                end else begin
                    oldest_pose = expected_poses.pop_front();
                    if (m_pos_x !== oldest_pose.pos_x || m_pos_y !== oldest_pose.pos_y ||
                        m_heading !== oldest_pose.heading) begin
                        errors++;
                        if (errors <= 10)
                            $display("pose mismatch: expected %h %h %h, got %h %h %h",
                                     oldest_pose.pos_x, oldest_pose.pos_y,
                                     oldest_pose.heading, m_pos_x, m_pos_y, m_heading);
                    end
                end
            end
        end
    end

    task automatic push_item(input logic req, input int l, input int r);
        pending_items.push_back('{req_type: req, left_count: 16'(l), right_count: 16'(r)});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Holds off new configuration until every pose has come back and the block rests.
    task automatic drain_poses();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_poses.size() != 0)
            @(negedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    // Mostly plausible driving with some spins, full-range noise and extremes.
    task automatic queue_random(input int n);
        int k, l, r;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 4) begin
                push_item(REQ_CLEAR, int'($urandom), int'($urandom));
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        l = int'($urandom_range(400)) - 200;
                        r = l + int'($urandom_range(40)) - 20;
                    end
                    6, 7: begin
                        l = int'($urandom);
                        r = int'($urandom);
                    end
                    8: begin
                        l = ($urandom_range(1)) ? 32767 : -32768;
                        r = ($urandom_range(1)) ? 32767 : -32768;
                        if ($urandom_range(3) == 0) r = int'($urandom_range(1)) - 1;
                    end
                    default: begin
                        l = int'($urandom_range(2000)) - 1000;
                        r = -l;
                    end
                endcase
                push_item(1'b1, l, r);
            end
        end
    endtask

    initial begin : stimulus
        int                p;
        logic [CFG_W-1:0]  mpc, gain;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default scaling: extremes of both wheels, spins and clears.
        write_reg(REG_METRES_PER_COUNT, MPC_RESET);
        write_reg(REG_HEADING_GAIN, GAIN_RESET);
        push_item(REQ_CLEAR, 0, 0);
        push_item(1'b1, 32767, 32767);
        push_item(1'b1, -32768, -32768);
        push_item(1'b1, 32767, -32768);
        push_item(1'b1, -32768, 32767);
        push_item(1'b1, 0, 0);
        push_item(1'b1, 100, -100);
        push_item(1'b1, 1, 0);
        push_item(1'b1, 0, -1);
        push_item(REQ_CLEAR, -1, -1);
        drain_poses();

        // Largest scaling, no turning: x runs into both saturation limits.
        write_reg(REG_METRES_PER_COUNT, 32'hFFFFFFFF);
        write_reg(REG_HEADING_GAIN, 32'd0);
        repeat (3) push_item(1'b1, 32767, 32767);
        repeat (4) push_item(1'b1, -32768, -32768);
        push_item(REQ_CLEAR, 0, 0);
        drain_poses();

        // Largest gain: large turns within one interval and heading wrap.
        write_reg(REG_HEADING_GAIN, 32'hFFFFFFFF);
        repeat (3) push_item(1'b1, 32767, -32768);
        repeat (2) push_item(1'b1, -32768, 32767);
        drain_poses();

        // Zero scaling: nothing moves at all.
        write_reg(REG_METRES_PER_COUNT, 32'd0);
        push_item(1'b1, 1234, -4321);
        push_item(1'b1, 32767, 32767);
        drain_poses();

        // Random phases, each with its own register setting.
        for (p = 0; p < 6; p++) begin
            case ($urandom_range(4))
                0: mpc = MPC_RESET;
                1: mpc = 32'hFFFFFFFF;
                2: mpc = $urandom;
                default: mpc = $urandom >> $urandom_range(24, 8);
            endcase
            case ($urandom_range(4))
                0: gain = GAIN_RESET;
                1: gain = 32'hFFFFFFFF;
                2: gain = 32'd0;
                default: gain = $urandom;
            endcase
            write_reg(REG_METRES_PER_COUNT, mpc);
            write_reg(REG_HEADING_GAIN, gain);
            queue_random(275);
            drain_poses();
        end

        if (errors == 0 && expected_poses.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ddo_pkg.sv
rtl/core/differential_drive_odometry.sv
test/testbench.sv
